/* rtl/core/itd_pkg.sv */
// shared types and constants of the text feed deframer
`timescale 1ns / 1ps
package itd_pkg;

	localparam int MAX_LENGTH = 65535;
	localparam int LEN_CAP_I = (MAX_LENGTH < 65535) ? MAX_LENGTH : 65535;
	localparam logic [15:0] LEN_CAP = 16'(LEN_CAP_I);

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_E       = 8'h45;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_M       = 8'h4D;
	localparam logic [7:0] CH_X       = 8'h58;
	localparam logic [7:0] CH_B       = 8'h42;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic [15:0] SEQ_HEADER = 16'd10;
	localparam logic [6:0] SIZE_NEW       = 7'(66 + 16 + 1);
	localparam logic [6:0] SIZE_MODIFY    = 7'(55 + 16 + 1);
	localparam logic [6:0] SIZE_CANCEL    = 7'(8 + 15 + 1);
	localparam logic [6:0] SIZE_ERRMSG    = 7'(101 + 1);
	localparam logic [6:0] SIZE_HEARTBEAT = 7'(1 + 1);

	localparam logic [2:0] KIND_END       = 3'd0;
	localparam logic [2:0] KIND_HEARTBEAT = 3'd1;
	localparam logic [2:0] KIND_ERRMSG    = 3'd2;
	localparam logic [2:0] KIND_NEW       = 3'd3;
	localparam logic [2:0] KIND_MODIFY    = 3'd4;
	localparam logic [2:0] KIND_CANCEL    = 3'd5;
	localparam logic [2:0] KIND_SNAPSHOT  = 3'd6;

	localparam logic [2:0] ERR_OK         = 3'd0;
	localparam logic [2:0] ERR_SESSION    = 3'd1;
	localparam logic [2:0] ERR_INNER      = 3'd2;
	localparam logic [2:0] ERR_SIZE       = 3'd3;
	localparam logic [2:0] ERR_SIDE       = 3'd4;
	localparam logic [2:0] ERR_DIGITS     = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  err;
		logic [15:0] len;
		logic        buy;
		logic [55:0] pair;
		logic [49:0] id;
	} itd_event_t;

endpackage

/* rtl/core/itd_parser.sv */
// message state and per-byte parse logic of the deframer
`timescale 1ns / 1ps
module itd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	output logic                  ev_valid,
	output itd_pkg::itd_event_t   ev
);

	logic        in_msg_q;
	logic [15:0] pos_q;
	logic [2:0]  kind_q;
	logic [6:0]  exp_q;
	logic [2:0]  perr_q;
	logic        side_q;
	logic [55:0] pair_q;
	logic [49:0] id_q;
	logic [1:0]  fend_q;

	logic        n_in;
	logic [15:0] n_pos;
	logic [2:0]  n_kind;
	logic [6:0]  n_exp;
	logic [2:0]  n_perr;
	logic        n_side;
	logic [55:0] n_pair;
	logic [49:0] n_id;
	logic [1:0]  n_fend;

	always_comb begin
		logic        lf;
		logic [15:0] count;
		logic        fin;
		logic        direct;
		logic [15:0] direct_len;
		logic [2:0]  direct_err;
		logic [15:0] ip;
		logic [15:0] pbase;
		logic [15:0] ibase;
		logic [15:0] pk;
		logic        order_kind;
		logic [2:0]  ferr;
		logic        is_digit;

		lf         = (data_byte == itd_pkg::CH_NEWLINE);
		count      = (pos_q < itd_pkg::LEN_CAP) ? pos_q + 16'd1 : itd_pkg::LEN_CAP;
		fin        = 1'b0;
		direct     = 1'b0;
		direct_len = 16'd0;
		direct_err = itd_pkg::ERR_OK;
		ip         = pos_q - itd_pkg::SEQ_HEADER;
		pbase      = (kind_q == itd_pkg::KIND_NEW) ? 16'd2 : 16'd1;
		ibase      = pbase + 16'd7;
		pk         = ip - pbase;
		is_digit   = (data_byte >= itd_pkg::CH_ZERO) && (data_byte <= itd_pkg::CH_NINE);

		n_in   = in_msg_q;
		n_pos  = pos_q;
		n_kind = kind_q;
		n_exp  = exp_q;
		n_perr = perr_q;
		n_side = side_q;
		n_pair = pair_q;
		n_id   = id_q;
		n_fend = fend_q;

		if (!in_msg_q) begin
			// type byte opens a fresh message
			n_in   = 1'b1;
			n_pos  = 16'd1;
			n_kind = itd_pkg::KIND_END;
			n_exp  = 7'd0;
			n_perr = itd_pkg::ERR_OK;
			n_side = 1'b0;
			n_pair = '0;
			n_id   = '0;
			n_fend = 2'b00;
			case (data_byte)
				itd_pkg::CH_S: begin
				end
				itd_pkg::CH_H: begin
					n_kind = itd_pkg::KIND_HEARTBEAT;
					n_exp  = itd_pkg::SIZE_HEARTBEAT;
				end
				itd_pkg::CH_E: begin
					n_kind = itd_pkg::KIND_ERRMSG;
					n_exp  = itd_pkg::SIZE_ERRMSG;
				end
				default: begin
					n_perr = itd_pkg::ERR_SESSION;
					if (lf) begin
						direct     = 1'b1;
						direct_err = itd_pkg::ERR_SESSION;
						direct_len = 16'd1;
					end
				end
			endcase
		end else begin
			n_pos = count;
			if (perr_q != itd_pkg::ERR_OK) begin
				fin = lf;
			end else if (kind_q == itd_pkg::KIND_HEARTBEAT || kind_q == itd_pkg::KIND_ERRMSG) begin
				if ({1'b0, pos_q} + 17'd1 == {10'd0, exp_q}) begin
					if (lf) begin
						fin = 1'b1;
					end else begin
						n_perr = itd_pkg::ERR_SIZE;
					end
				end
			end else if (kind_q == itd_pkg::KIND_END) begin
				if (pos_q == 16'd1 && lf) begin
					direct     = 1'b1;
					direct_err = itd_pkg::ERR_OK;
					direct_len = count;
				end else if (pos_q == itd_pkg::SEQ_HEADER) begin
					case (data_byte)
						itd_pkg::CH_N: begin
							n_kind = itd_pkg::KIND_NEW;
							n_exp  = itd_pkg::SIZE_NEW;
						end
						itd_pkg::CH_M: begin
							n_kind = itd_pkg::KIND_MODIFY;
							n_exp  = itd_pkg::SIZE_MODIFY;
						end
						itd_pkg::CH_X: begin
							n_kind = itd_pkg::KIND_CANCEL;
							n_exp  = itd_pkg::SIZE_CANCEL;
						end
						itd_pkg::CH_S: begin
							n_kind = itd_pkg::KIND_SNAPSHOT;
							n_exp  = 7'd0;
						end
						default: begin
							n_perr = itd_pkg::ERR_INNER;
						end
					endcase
					fin = lf;
				end else if (pos_q > itd_pkg::SEQ_HEADER) begin
					fin = lf;
				end
			end else if (lf) begin
				fin = 1'b1;
			end else if (kind_q >= itd_pkg::KIND_NEW && kind_q <= itd_pkg::KIND_CANCEL) begin
				if (kind_q == itd_pkg::KIND_NEW && ip == 16'd1) begin
					if (data_byte == itd_pkg::CH_B) begin
						n_side = 1'b1;
					end else if (data_byte == itd_pkg::CH_S) begin
						n_side = 1'b0;
					end else begin
						n_perr = itd_pkg::ERR_SIDE;
					end
				end else if (ip >= pbase && pk < 16'd7) begin
					// pair text, zeroed from the first space on
					if (data_byte == itd_pkg::CH_SPACE) begin
						n_fend[0] = 1'b1;
					end else if (!fend_q[0]) begin
						for (int k = 0; k < 7; k++) begin
							if (pk[2:0] == 3'(k)) begin
								n_pair[8*(6-k) +: 8] = pair_q[8*(6-k) +: 8] | data_byte;
							end
						end
					end
				end else if (ip >= ibase && ip < ibase + 16'd15) begin
					if (data_byte == itd_pkg::CH_SPACE) begin
						if (ip == ibase) begin
							n_perr = itd_pkg::ERR_DIGITS;
						end else begin
							n_fend[1] = 1'b1;
						end
					end else if (is_digit && !fend_q[1]) begin
						n_id = (id_q << 3) + (id_q << 1) + {42'd0, data_byte - itd_pkg::CH_ZERO};
					end else begin
						n_perr = itd_pkg::ERR_DIGITS;
					end
				end
			end
		end

		// end of message: size check against the updated kind
		order_kind = (n_kind >= itd_pkg::KIND_NEW) && (n_kind <= itd_pkg::KIND_CANCEL);
		ferr = n_perr;
		if (order_kind && ({1'b0, count} != {10'd0, n_exp} + 17'd10)) begin
			ferr = itd_pkg::ERR_SIZE;
		end

		ev_valid = fin | direct;
		ev       = '0;
		if (direct) begin
			ev.kind = itd_pkg::KIND_END;
			ev.err  = direct_err;
			ev.len  = direct_len;
		end else if (fin) begin
			ev.kind = n_kind;
			ev.err  = ferr;
			ev.len  = count;
			if (ferr == itd_pkg::ERR_OK && order_kind) begin
				ev.buy  = (n_kind == itd_pkg::KIND_NEW) ? n_side : 1'b0;
				ev.pair = n_pair;
				ev.id   = n_id;
			end
		end

		if (fin | direct) begin
			n_in   = 1'b0;
			n_pos  = 16'd0;
			n_kind = itd_pkg::KIND_END;
			n_exp  = 7'd0;
			n_perr = itd_pkg::ERR_OK;
			n_side = 1'b0;
			n_pair = '0;
			n_id   = '0;
			n_fend = 2'b00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			pos_q    <= 16'd0;
			kind_q   <= itd_pkg::KIND_END;
			exp_q    <= 7'd0;
			perr_q   <= itd_pkg::ERR_OK;
			side_q   <= 1'b0;
			pair_q   <= '0;
			id_q     <= '0;
			fend_q   <= 2'b00;
		end else if (step) begin
			in_msg_q <= n_in;
			pos_q    <= n_pos;
			kind_q   <= n_kind;
			exp_q    <= n_exp;
			perr_q   <= n_perr;
			side_q   <= n_side;
			pair_q   <= n_pair;
			id_q     <= n_id;
			fend_q   <= n_fend;
		end
	end

`ifndef SYNTHESIS
	// between messages all state sits at its cleared value
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_msg_q |-> (pos_q == 16'd0 && perr_q == itd_pkg::ERR_OK && id_q == '0))
		else $error("parser state not cleared between messages");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q <= itd_pkg::KIND_SNAPSHOT)
		else $error("message kind out of range");
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && ev.err != itd_pkg::ERR_OK) |-> (!ev.buy && ev.pair == '0 && ev.id == '0))
		else $error("error event carries order fields");
`endif

endmodule

/* rtl/core/itd_out_reg.sv */
// result register of the deframer
`timescale 1ns / 1ps
module itd_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  itd_pkg::itd_event_t   ev_in,
	input  logic                  taken,
	output logic                  valid,
	output itd_pkg::itd_event_t   ev_out
);

	logic                valid_q;
	itd_pkg::itd_event_t ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q <= ev_in;
		end
	end

	assign valid  = valid_q;
	assign ev_out = ev_q;

endmodule

/* rtl/core/itch_text_feed_deframer.sv */
// top level of the text feed deframer: input register, parser, result register
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  byte in  | byte_valid / byte_ready  | data_byte
//  event out| event_valid / event_ready| event_kind, fault_code, message_length,
//           |                          | is_buy, pair_text, order_id
//
// one byte per clock sustained unless a waiting event holds the input; an event is
// valid once the byte that closes its message has left the input register and
// its event is loaded into the result register; all parse state lives in one
// set of registers updated once per byte; arst_n clears the handshake and
// message state; no warm-up period; while an event waits the input register still takes one byte
`timescale 1ns / 1ps
module itch_text_feed_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	output logic        event_valid,
	input  logic        event_ready,
	output logic [2:0]  event_kind,
	output logic [2:0]  fault_code,
	output logic [15:0] message_length,
	output logic        is_buy,
	output logic [55:0] pair_text,
	output logic [49:0] order_id
);

	logic                byte_v_s1;
	logic [7:0]          byte_s1;
	logic                step;
	logic                ev_valid;
	itd_pkg::itd_event_t ev;
	itd_pkg::itd_event_t ev_out;

	// parse a held byte whenever the result register can take its event
	assign step       = byte_v_s1 && (!event_valid || event_ready);
	assign byte_ready = !byte_v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (byte_ready) begin
			byte_v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= data_byte;
		end
	end

	itd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.ev_valid  (ev_valid),
		.ev        (ev)
	);

	itd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && ev_valid),
		.ev_in  (ev),
		.taken  (event_valid && event_ready),
		.valid  (event_valid),
		.ev_out (ev_out)
	);

	assign event_kind     = ev_out.kind;
	assign fault_code     = ev_out.err;
	assign message_length = ev_out.len;
	assign is_buy         = ev_out.buy;
	assign pair_text      = ev_out.pair;
	assign order_id       = ev_out.id;

`ifndef SYNTHESIS
	// a byte stuck behind a waiting event must stay put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_v_s1 && event_valid && !event_ready) |=> (byte_v_s1 && $stable(byte_s1)))
		else $error("held byte lost while event waits");
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (byte_v_s1 && event_valid))
		else $error("input stalled without a waiting event");
	a_event_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && !event_ready) |=> (event_valid && $stable(ev_out)))
		else $error("waiting event changed or dropped");
`endif

endmodule

/* bench/tb.sv */
// self-checking bench for the text feed deframer: byte stream in, message events out
`timescale 1ns / 1ps
module tb;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 120;
	localparam int FEED_BYTES  = 1450;
	localparam logic [7:0] CH_LOGIN_A = 8'h41;
	localparam logic [7:0] CH_LOGIN_J = 8'h4A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        event_valid;
	logic        event_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [2:0]  fault_code;
	logic [15:0] message_length;
	logic        is_buy;
	logic [55:0] pair_text;
	logic [49:0] order_id;

	itch_text_feed_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_kind(event_kind),
		.fault_code(fault_code),
		.message_length(message_length),
		.is_buy(is_buy),
		.pair_text(pair_text),
		.order_id(order_id)
	);

	always #2 clk = ~clk;

	logic [7:0]          feed_q[$];
	logic [7:0]          msg_buf[$];
	itd_pkg::itd_event_t events_due[$];
	itd_pkg::itd_event_t tx_ev;
	itd_pkg::itd_event_t rx_want;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          bytes_taken = 0;
	int          quiet = 0;
	int          mismatches = 0;
	int          events_checked = 0;
	int          error_events = 0;
	int          msgs_made = 0;

	// ---------------------------------------------------------------
	// message splitter state, mirrors the block one byte at a time
	bit          fr_open;
	int unsigned fr_pos;
	logic [2:0]  fr_kind;
	int          fr_need;
	logic [2:0]  fr_err;
	logic        fr_buy;
	logic [55:0] fr_pair;
	logic [49:0] fr_id;
	bit          fr_pair_end;
	bit          fr_id_tail;

	function automatic void frame_clear();
		fr_open = 1'b0;
		fr_pos = 0;
		fr_kind = itd_pkg::KIND_END;
		fr_need = 0;
		fr_err = itd_pkg::ERR_OK;
		fr_buy = 1'b0;
		fr_pair = '0;
		fr_id = '0;
		fr_pair_end = 1'b0;
		fr_id_tail = 1'b0;
	endfunction

	function automatic itd_pkg::itd_event_t frame_close(input int unsigned cnt);
		itd_pkg::itd_event_t ev;
		bit order;
		ev = '0;
		order = (fr_kind >= itd_pkg::KIND_NEW && fr_kind <= itd_pkg::KIND_CANCEL);
		ev.kind = fr_kind;
		ev.len = 16'(cnt);
		ev.err = fr_err;
		// size mismatch wins over side and digit errors
		if (order && int'(cnt) - int'(itd_pkg::SEQ_HEADER) != fr_need)
			ev.err = itd_pkg::ERR_SIZE;
		if (ev.err == itd_pkg::ERR_OK && order) begin
			ev.buy = (fr_kind == itd_pkg::KIND_NEW) ? fr_buy : 1'b0;
			ev.pair = fr_pair;
			ev.id = fr_id;
		end
		frame_clear();
		return ev;
	endfunction

	function automatic void frame_field(input int unsigned ip, input logic [7:0] b);
		int unsigned pb, ib;
		pb = (fr_kind == itd_pkg::KIND_NEW) ? 2 : 1;
		ib = pb + 7;
		if (fr_kind == itd_pkg::KIND_NEW && ip == 1) begin
			if (b == itd_pkg::CH_B)
				fr_buy = 1'b1;
			else if (b == itd_pkg::CH_S)
				fr_buy = 1'b0;
			else
				fr_err = itd_pkg::ERR_SIDE;
		end else if (ip >= pb && ip < pb + 7) begin
			if (b == itd_pkg::CH_SPACE)
				fr_pair_end = 1'b1;
			if (!fr_pair_end)
				fr_pair = fr_pair | (56'(b) << (8 * (6 - (ip - pb))));
		end else if (ip >= ib && ip < ib + 15) begin
			if (b == itd_pkg::CH_SPACE) begin
				if (ip == ib)
					fr_err = itd_pkg::ERR_DIGITS;
				else
					fr_id_tail = 1'b1;
			end else if (b >= itd_pkg::CH_ZERO && b <= itd_pkg::CH_NINE && !fr_id_tail) begin
				fr_id = 50'(64'(fr_id) * 10 + 64'(b - itd_pkg::CH_ZERO));
			end else begin
				fr_err = itd_pkg::ERR_DIGITS;
			end
		end
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b,
			output itd_pkg::itd_event_t ev);
		int unsigned pos, cnt;
		bit lf;
		ev = '0;
		lf = (b == itd_pkg::CH_NEWLINE);
		if (!fr_open) begin
			frame_clear();
			fr_open = 1'b1;
			fr_pos = 1;
			if (b == itd_pkg::CH_S) begin
				fr_kind = itd_pkg::KIND_END;
			end else if (b == itd_pkg::CH_H) begin
				fr_kind = itd_pkg::KIND_HEARTBEAT;
				fr_need = int'(itd_pkg::SIZE_HEARTBEAT);
			end else if (b == itd_pkg::CH_E) begin
				fr_kind = itd_pkg::KIND_ERRMSG;
				fr_need = int'(itd_pkg::SIZE_ERRMSG);
			end else begin
				fr_err = itd_pkg::ERR_SESSION;
			end
			// newline as a type byte reports at once
			if (fr_err != itd_pkg::ERR_OK && lf) begin
				ev = frame_close(1);
				return 1'b1;
			end
			return 1'b0;
		end
		pos = fr_pos;
		cnt = (pos < itd_pkg::LEN_CAP_I) ? pos + 1 : itd_pkg::LEN_CAP_I;
		fr_pos = cnt;
		if (fr_err == itd_pkg::ERR_OK) begin
			if (fr_kind == itd_pkg::KIND_HEARTBEAT || fr_kind == itd_pkg::KIND_ERRMSG) begin
				if (int'(pos) + 1 != fr_need)
					return 1'b0;
				if (!lf) begin
					fr_err = itd_pkg::ERR_SIZE;
					return 1'b0;
				end
			end else if (fr_kind == itd_pkg::KIND_END) begin
				if (pos == 1 && lf) begin
					ev = frame_close(cnt);
					return 1'b1;
				end
				// header bytes are taken blindly, newline included
				if (pos < itd_pkg::SEQ_HEADER)
					return 1'b0;
				if (b == itd_pkg::CH_N) begin
					fr_kind = itd_pkg::KIND_NEW;
					fr_need = int'(itd_pkg::SIZE_NEW);
				end else if (b == itd_pkg::CH_M) begin
					fr_kind = itd_pkg::KIND_MODIFY;
					fr_need = int'(itd_pkg::SIZE_MODIFY);
				end else if (b == itd_pkg::CH_X) begin
					fr_kind = itd_pkg::KIND_CANCEL;
					fr_need = int'(itd_pkg::SIZE_CANCEL);
				end else if (b == itd_pkg::CH_S) begin
					fr_kind = itd_pkg::KIND_SNAPSHOT;
					fr_need = 0;
				end else begin
					fr_err = itd_pkg::ERR_INNER;
				end
			end else if (!lf && fr_kind >= itd_pkg::KIND_NEW &&
					fr_kind <= itd_pkg::KIND_CANCEL) begin
				frame_field(pos - itd_pkg::SEQ_HEADER, b);
			end
		end
		if (!lf)
			return 1'b0;
		ev = frame_close(cnt);
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// stream builders

	function automatic logic [7:0] any_text();
		logic [7:0] b;
		b = 8'($urandom_range(0, 254));
		if (b >= itd_pkg::CH_NEWLINE)
			b = b + 8'd1;
		return b;
	endfunction

	function automatic logic [7:0] letter();
		return 8'($urandom_range(65, 90));
	endfunction

	task automatic hdr_to_feed();
		feed_q.push_back(itd_pkg::CH_S);
		feed_q.push_back(any_text());
		repeat (8)
			feed_q.push_back(($urandom_range(0, 15) == 0) ? itd_pkg::CH_NEWLINE : any_text());
	endtask

	// space_at 0..6 cuts the pair there, 7 is a full pair, negative is raw bytes
	task automatic pair_into_buf(input int space_at);
		int i;
		for (i = 0; i < 7; i++) begin
			if (space_at < 0)
				msg_buf.push_back(any_text());
			else if (i == space_at)
				msg_buf.push_back(itd_pkg::CH_SPACE);
			else if (space_at < 7 && i > space_at)
				msg_buf.push_back($urandom_range(0, 1) ? itd_pkg::CH_SPACE : letter());
			else
				msg_buf.push_back(letter());
		end
	endtask

	// 0 random digits, 1 all nines, 2 single zero, 3 all zeros,
	// 4 leading space, 5 digit after trailing space, 6 foreign char
	task automatic id_into_buf(input int sel);
		logic [7:0] f[15];
		logic [7:0] c;
		int n, i;
		n = (sel == 5) ? $urandom_range(1, 13) : (sel == 0) ? $urandom_range(1, 15) :
			(sel == 2) ? 1 : 15;
		for (i = 0; i < 15; i++)
			f[i] = (i < n) ? 8'(itd_pkg::CH_ZERO + $urandom_range(0, 9)) : itd_pkg::CH_SPACE;
		case (sel)
			1: for (i = 0; i < 15; i++) f[i] = itd_pkg::CH_NINE;
			2: f[0] = itd_pkg::CH_ZERO;
			3: for (i = 0; i < 15; i++) f[i] = itd_pkg::CH_ZERO;
			4: f[0] = itd_pkg::CH_SPACE;
			5: f[n + 1] = 8'(itd_pkg::CH_ZERO + $urandom_range(0, 9));
			6: begin
				case ($urandom_range(0, 2))
					0: c = CH_MINUS;
					1: c = CH_PLUS;
					default: begin
						c = any_text();
						while (c == itd_pkg::CH_SPACE ||
								(c >= itd_pkg::CH_ZERO && c <= itd_pkg::CH_NINE))
							c = any_text();
					end
				endcase
				f[$urandom_range(0, 14)] = c;
			end
			default: ;
		endcase
		for (i = 0; i < 15; i++)
			msg_buf.push_back(f[i]);
	endtask

	// side_sel: 0 buy, 1 sell, 2 junk
	task automatic add_order(input logic [7:0] ch, input int side_sel, input int space_at,
			input int id_sel, input int len_delta);
		logic [7:0] s;
		int need, i;
		hdr_to_feed();
		msg_buf.delete();
		msg_buf.push_back(ch);
		if (ch == itd_pkg::CH_N) begin
			s = (side_sel == 0) ? itd_pkg::CH_B : itd_pkg::CH_S;
			if (side_sel == 2) begin
				s = any_text();
				while (s == itd_pkg::CH_B || s == itd_pkg::CH_S)
					s = any_text();
			end
			msg_buf.push_back(s);
		end
		pair_into_buf(space_at);
		id_into_buf(id_sel);
		need = (ch == itd_pkg::CH_N) ? int'(itd_pkg::SIZE_NEW) :
			(ch == itd_pkg::CH_M) ? int'(itd_pkg::SIZE_MODIFY) : int'(itd_pkg::SIZE_CANCEL);
		// price and amount are filler as far as the block is concerned
		while (msg_buf.size() < need - 1)
			msg_buf.push_back(any_text());
		if (len_delta < 0) begin
			repeat (-len_delta)
				if (msg_buf.size() > 1)
					void'(msg_buf.pop_back());
		end else begin
			repeat (len_delta)
				msg_buf.push_back(any_text());
		end
		for (i = 0; i < msg_buf.size(); i++)
			feed_q.push_back(msg_buf[i]);
		feed_q.push_back(itd_pkg::CH_NEWLINE);
	endtask

	task automatic add_fixed(input logic [7:0] ch, input logic [7:0] last);
		repeat (1) feed_q.push_back(ch);
		repeat (((ch == itd_pkg::CH_H) ? int'(itd_pkg::SIZE_HEARTBEAT) :
				int'(itd_pkg::SIZE_ERRMSG)) - 2)
			feed_q.push_back(($urandom_range(0, 19) == 0) ? itd_pkg::CH_NEWLINE : any_text());
		feed_q.push_back(last);
		if (last != itd_pkg::CH_NEWLINE) begin
			repeat ($urandom_range(0, 6))
				feed_q.push_back(any_text());
			feed_q.push_back(itd_pkg::CH_NEWLINE);
		end
	endtask

	task automatic add_snapshot(input int body);
		hdr_to_feed();
		feed_q.push_back(itd_pkg::CH_S);
		repeat (body)
			feed_q.push_back(any_text());
		feed_q.push_back(itd_pkg::CH_NEWLINE);
	endtask

	task automatic add_unknown(input logic [7:0] ch, input int body);
		feed_q.push_back(ch);
		if (ch != itd_pkg::CH_NEWLINE) begin
			repeat (body)
				feed_q.push_back(any_text());
			feed_q.push_back(itd_pkg::CH_NEWLINE);
		end
	endtask

	task automatic add_bad_inner(input logic [7:0] ch, input int body);
		hdr_to_feed();
		add_unknown(ch, body);
	endtask

	// ---------------------------------------------------------------
	// byte driver, predicts on every accepted beat

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (byte_valid && byte_ready) begin
				if (deframe_byte(data_byte, tx_ev))
					events_due.push_back(tx_ev);
				bytes_taken <= bytes_taken + 1;
			end
			if (!byte_valid || byte_ready) begin
				if (tx_gap > 0) begin
					tx_gap = tx_gap - 1;
					byte_valid <= 1'b0;
				end else if (feed_q.size() > 300 && $urandom_range(0, 11) == 0) begin
					tx_gap = $urandom_range(0, 7);
					byte_valid <= 1'b0;
				end else if (feed_q.size() != 0) begin
					byte_valid <= 1'b1;
					data_byte <= feed_q.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// one long back-pressure stretch once events are flowing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && event_valid && bytes_taken > 400) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// event monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (event_valid && event_ready) begin
				if (events_due.size() == 0) begin
					$display("%0t ns: event with nothing expected, expected none, %s %0d %0d %0d",
						$time, "got kind/code/len", event_kind, fault_code, message_length);
					mismatches++;
				end else begin
					rx_want = events_due.pop_front();
					check_field("event_kind", 64'(rx_want.kind), 64'(event_kind));
					check_field("fault_code", 64'(rx_want.err), 64'(fault_code));
					check_field("message_length", 64'(rx_want.len), 64'(message_length));
					check_field("is_buy", 64'(rx_want.buy), 64'(is_buy));
					check_field("pair_text", 64'(rx_want.pair), 64'(pair_text));
					check_field("order_id", 64'(rx_want.id), 64'(order_id));
					if (rx_want.err != itd_pkg::ERR_OK)
						error_events++;
				end
				events_checked++;
			end
			if (hold_left > 0) begin
				event_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap = rx_gap - 1;
				event_ready <= 1'b0;
			end else if (feed_q.size() > 300 && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 7);
				event_ready <= 1'b0;
			end else begin
				event_ready <= 1'b1;
			end
		end
	end

	// stall watchdog: any accepted beat on either side resets it
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (event_valid && event_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t ns: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ---------------------------------------------------------------

	initial begin : stimulus
		int pick, flaw, delta;
		logic [7:0] t;
		frame_clear();

		// directed: each message type, field extremes, every error path
		feed_q.push_back(itd_pkg::CH_S);
		feed_q.push_back(itd_pkg::CH_NEWLINE);
		add_fixed(itd_pkg::CH_H, itd_pkg::CH_NEWLINE);
		add_fixed(itd_pkg::CH_E, itd_pkg::CH_NEWLINE);
		add_order(itd_pkg::CH_N, 0, 7, 1, 0);
		add_order(itd_pkg::CH_N, 1, 3, 2, 0);
		add_order(itd_pkg::CH_M, 0, 0, 3, 0);
		add_order(itd_pkg::CH_X, 0, 7, 0, 0);
		add_snapshot(0);
		add_unknown(itd_pkg::CH_NEWLINE, 0);
		add_unknown(CH_LOGIN_A, 5);
		add_unknown(CH_LOGIN_J, 0);
		add_unknown(8'hFF, 3);
		add_bad_inner(8'h00, 4);
		add_bad_inner(itd_pkg::CH_NEWLINE, 0);
		add_fixed(itd_pkg::CH_H, itd_pkg::CH_H);
		add_fixed(itd_pkg::CH_E, 8'hFF);
		add_order(itd_pkg::CH_N, 2, 7, 0, 0);
		add_order(itd_pkg::CH_N, 0, 7, 4, 0);
		add_order(itd_pkg::CH_M, 0, 7, 5, 0);
		add_order(itd_pkg::CH_X, 0, 7, 6, 0);
		add_order(itd_pkg::CH_N, 2, 7, 6, -3);
		add_order(itd_pkg::CH_X, 0, 7, 0, 4);
		add_order(itd_pkg::CH_M, 0, 7, 0, -1);
		msgs_made = 23;

		// random traffic, mostly well-formed with random content
		while (feed_q.size() < FEED_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				feed_q.push_back(itd_pkg::CH_S);
				feed_q.push_back(itd_pkg::CH_NEWLINE);
			end else if (pick < 20) begin
				add_fixed(itd_pkg::CH_H,
					($urandom_range(0, 9) == 0) ? any_text() : itd_pkg::CH_NEWLINE);
			end else if (pick < 25) begin
				add_fixed(itd_pkg::CH_E,
					($urandom_range(0, 5) == 0) ? any_text() : itd_pkg::CH_NEWLINE);
			end else if (pick < 65) begin
				t = (pick < 45) ? itd_pkg::CH_X : (pick < 55) ? itd_pkg::CH_M : itd_pkg::CH_N;
				flaw = $urandom_range(0, 11);
				delta = $urandom_range(1, 5);
				if ($urandom_range(0, 1))
					delta = -delta;
				add_order(t, (flaw == 7) ? 2 : $urandom_range(0, 1),
					($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 7),
					(flaw == 6 || flaw == 8) ? $urandom_range(4, 6) : $urandom_range(0, 3),
					(flaw == 6 || flaw == 9) ? delta : 0);
			end else if (pick < 73) begin
				add_snapshot($urandom_range(0, 40));
			end else if (pick < 81) begin
				t = 8'($urandom_range(0, 255));
				while (t == itd_pkg::CH_S || t == itd_pkg::CH_H || t == itd_pkg::CH_E)
					t = 8'($urandom_range(0, 255));
				add_unknown(t, $urandom_range(0, 10));
			end else if (pick < 87) begin
				t = 8'($urandom_range(0, 255));
				while (t == itd_pkg::CH_N || t == itd_pkg::CH_M || t == itd_pkg::CH_X ||
						t == itd_pkg::CH_S)
					t = 8'($urandom_range(0, 255));
				add_bad_inner(t, $urandom_range(0, 20));
			end else begin
				// line noise, may run into the next message
				repeat ($urandom_range(1, 12))
					feed_q.push_back(8'($urandom_range(0, 255)));
			end
			msgs_made++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || byte_valid)
			@(posedge clk);
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("fed %0d bytes in about %0d messages; checked %0d events",
			bytes_taken, msgs_made, events_checked);
		$display("%0d events carried error codes; event side held off once for %0d cycles",
			error_events, HOLD_CYCLES);
		if (mismatches == 0 && events_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0t ns: %0d mismatches, %0d events still expected",
				$time, mismatches, events_due.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
